FILE: rtl/ism_pkg.sv
// Shared constants, codes and types for the Ising Metropolis spin-update block.
// Used by the top level ising_metropolis_spin_update; no dependencies.
`timescale 1ns / 1ps

package ism_pkg;

	// Lattice side length. It must be a power of two from 4 to 1024, so that a
	// linear site index splits into row and column bits and the neighbor
	// coordinates wrap by plain modular add and subtract.
	localparam int SIDE   = 128;
	localparam int SIDE_W = $clog2(SIDE);
	localparam int LAT_W  = 2 * SIDE_W;
	localparam int SITES  = SIDE * SIDE;

	// Field widths of the stream words.
	localparam int SITE_W = 14;
	localparam int DRAW_W = 14;
	localparam int THR_W  = 14;
	localparam int DE_W   = 5;
	localparam int MAG_W  = 16;

	// Site index widened so that it always covers row and column bits.
	localparam int EXT_W = (SITE_W > LAT_W) ? SITE_W : LAT_W;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	// Magnetization after reset: minus the site count, modulo 2^16.
	localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(0 - SITES);

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic {
		CFG_THR_FOUR  = 1'b0,
		CFG_THR_EIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_CUR,
		S_RD_UP,
		S_RD_DN,
		S_EVAL
	} state_t;

endpackage

FILE: rtl/ism_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module ism_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ising_metropolis_spin_update.sv
// Top level of the 2D Ising Metropolis single-spin-flip block.
// Depends on ism_pkg and on ism_ram, which holds the spin lattice one row per word.
`timescale 1ns / 1ps
//
// Usage:
// Input words arrive on the s_ stream. s_tuser carries the opcode (load one
// spin or attempt an update); s_tdata carries the site, the spin to load and
// the random draw. Each input word produces exactly one result word on the
// m_ stream with the flip flag, the new spin, the energy change and the
// running magnetization. The two acceptance thresholds are written on the
// cfg_ channel, which is always ready; write them only while the block is idle.
// Timing: the lattice sits in a single-port-read RAM, one row of SIDE spins per
// word. An update reads the site row, the row above and the row below in turn; a
// load reads only the site row. Either writes the site row back when the spin
// changes and the site is in range, and registers its result at that point.
// A new word is accepted only after the previous one leaves the evaluation step,
// so the block never takes a new word before it is through with the last one.
// After reset all spins are cleared by a pass over all SIDE rows, one row per
// cycle, during which s_tready is low; magnetization resets to minus the site
// count. When the receiver stalls, the result waits in the output register;
// the next word may still be accepted and processed up to its write-back.

module ising_metropolis_spin_update (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata: site_index [13:0], load_spin [14], random_draw [28:15], zero fill.
	input  logic [ism_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tuser: opcode [0].
	input  logic                               s_tuser,
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata: flipped [0], spin_after [1], energy_change [6:2],
	// magnetization [22:7], zero fill.
	output logic [ism_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [ism_pkg::THR_W-1:0]          cfg_data
);

	import ism_pkg::*;

	state_t state_q, state_nx;

	// Configuration registers.
	logic [THR_W-1:0] thr_four_q, thr_eight_q;

	// Latched item.
	logic              op_q;
	logic [SIDE_W-1:0] row_q, col_q;
	logic              in_range_q;
	logic              lspin_q;
	logic [DRAW_W-1:0] draw_q;

	// Neighborhood gathered from the RAM.
	logic [SIDE-1:0]   cur_row_q;
	logic              up_bit_q, dn_bit_q;

	logic [MAG_W-1:0]  mag_q;
	logic [SIDE_W-1:0] clr_q;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// Input unpacking.
	logic [SITE_W-1:0] in_site;
	logic [EXT_W-1:0]  in_site_ext;
	logic [SIDE_W-1:0] in_row, in_col;
	logic              in_range;
	logic              in_accept;

	// RAM port.
	logic              ram_we, ram_re;
	logic [SIDE_W-1:0] ram_waddr, ram_raddr;
	logic [SIDE-1:0]   ram_wdata, ram_rdata;

	// Evaluation.
	logic              out_free, eval_fire;
	logic              cur_spin;
	logic [2:0]        up_cnt, agree;
	logic signed [DE_W-1:0] delta;
	logic              accept_flip;
	logic              new_spin, changed;
	logic [SIDE-1:0]   new_row;
	logic [MAG_W-1:0]  mag_nx;
	logic              res_flipped, res_spin;
	logic [DE_W-1:0]   res_delta;

	assign in_site     = s_tdata[SITE_W-1:0];
	assign in_site_ext = EXT_W'(in_site);
	assign in_col      = in_site_ext[SIDE_W-1:0];
	assign in_row      = in_site_ext[SIDE_W +: SIDE_W];
	assign in_range    = ((EXT_W + 1)'(in_site) < (EXT_W + 1)'(SITES));
	assign in_accept   = s_tvalid && s_tready;

	assign out_free  = !m_valid_q || m_tready;
	assign eval_fire = (state_q == S_EVAL) && out_free;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == SIDE_W'(SIDE - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					state_nx = S_RD_CUR;
				end
			end
			S_RD_CUR: begin
				state_nx = (op_q == OP_LOAD) ? S_EVAL : S_RD_UP;
			end
			S_RD_UP: state_nx = S_RD_DN;
			S_RD_DN: state_nx = S_EVAL;
			S_EVAL: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_CLEAR;
		endcase
	end

	// FSM outputs: handshake and RAM control.
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = row_q;
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = new_row;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				s_tready  = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = in_row;
			end
			S_RD_CUR: begin
				ram_re    = 1'b1;
				ram_raddr = row_q - SIDE_W'(1);
			end
			S_RD_UP: begin
				ram_re    = 1'b1;
				ram_raddr = row_q + SIDE_W'(1);
			end
			S_RD_DN: begin
			end
			S_EVAL: begin
				ram_we = eval_fire && in_range_q && changed;
			end
			default: begin
			end
		endcase
	end

	ism_ram #(
		.WIDTH(SIDE),
		.DEPTH(SIDE)
	) u_spin_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Metropolis decision. The count of neighbors that agree with the site spin
	// fixes the energy change: 4 * agree - 8.
	always_comb begin
		cur_spin = cur_row_q[col_q];
		up_cnt   = 3'(up_bit_q) + 3'(dn_bit_q)
		         + 3'(cur_row_q[col_q - SIDE_W'(1)]) + 3'(cur_row_q[col_q + SIDE_W'(1)]);
		agree    = cur_spin ? up_cnt : (3'd4 - up_cnt);
		case (agree)
			3'd0:    delta = -5'sd8;
			3'd1:    delta = -5'sd4;
			3'd2:    delta = 5'sd0;
			3'd3:    delta = 5'sd4;
			default: delta = 5'sd8;
		endcase
		if (agree <= 3'd2) begin
			accept_flip = 1'b1;
		end else if (agree == 3'd3) begin
			accept_flip = draw_q < thr_four_q;
		end else begin
			accept_flip = draw_q < thr_eight_q;
		end

		if (op_q == OP_LOAD) begin
			new_spin = lspin_q;
		end else begin
			new_spin = cur_spin ^ accept_flip;
		end
		changed = new_spin != cur_spin;

		new_row        = cur_row_q;
		new_row[col_q] = new_spin;

		if (in_range_q && changed) begin
			mag_nx = mag_q + (new_spin ? MAG_W'(2) : {{(MAG_W - 2){1'b1}}, 2'b10});
		end else begin
			mag_nx = mag_q;
		end

		res_flipped = in_range_q && (op_q == OP_UPDATE) && accept_flip;
		res_spin    = in_range_q && new_spin;
		res_delta   = (in_range_q && (op_q == OP_UPDATE)) ? delta : '0;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			mag_q       <= MAG_RESET;
			thr_four_q  <= '0;
			thr_eight_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + SIDE_W'(1);
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_THR_FOUR:  thr_four_q  <= cfg_data;
					CFG_THR_EIGHT: thr_eight_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (eval_fire) begin
				mag_q     <= mag_nx;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q       <= s_tuser;
			row_q      <= in_row;
			col_q      <= in_col;
			in_range_q <= in_range;
			lspin_q    <= s_tdata[SITE_W];
			draw_q     <= s_tdata[SITE_W + 1 +: DRAW_W];
		end
		if (state_q == S_RD_CUR) begin
			cur_row_q <= ram_rdata;
		end
		if (state_q == S_RD_UP) begin
			up_bit_q <= ram_rdata[col_q];
		end
		if (state_q == S_RD_DN) begin
			dn_bit_q <= ram_rdata[col_q];
		end
		if (eval_fire) begin
			m_data_q <= OUT_TDATA_W'({mag_nx, res_delta, res_spin, res_flipped});
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

endmodule
